FILE: hw/rtl/postfix_expression_evaluator_assert.svh
// Assertion macros for the postfix evaluator.
// Used by the top level only; no dependencies.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PEE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/pee_pkg.sv
// Package for the postfix evaluator: character codes and controller/datapath commands.
// No dependencies.
package pee_pkg;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharCaret  = 8'h5E;
  localparam logic [7:0] CharPct    = 8'h25;

  typedef enum logic [2:0] {
    OpAdd, OpSub, OpMul, OpDiv, OpMod, OpPow
  } op_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_in;     // capture the incoming character
    logic push_digit;  // push the digit of the held character
    logic rd_right;    // pop right operand (issue memory read)
    logic lat_right;   // latch read data as right operand
    logic rd_left;     // pop left operand
    logic lat_left;    // latch read data as left operand
    logic start_alu;   // start the iterative unit
    logic push_res;    // push the unit result
    logic rd_top;      // read top of stack for output
    logic emit;        // load output register, clear stack and flags
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic last;
    logic alu_done;
  } sts_t;
endpackage

FILE: hw/rtl/pee_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pee_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: hw/rtl/pee_alu.sv
// Iterative arithmetic unit: add, sub, multiply at start, bit-serial divide and
// modulo, and square-and-multiply power. Depends on pee_pkg.
module pee_alu import pee_pkg::*; #(
  parameter int VW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  op_e           op_i,
  input  logic [VW-1:0] left_i,
  input  logic [VW-1:0] right_i,
  output logic          done_o,
  output logic [VW-1:0] result_o,
  output logic          dz_o
);
  localparam int CW = $clog2(VW + 1);
  typedef enum logic [1:0] {SIdle, SDiv, SPowMul, SPowSq} state_e;
  state_e state_q;
  op_e op_q;
  logic [VW-1:0] rem_q, quo_q, div_q, acc_q, base_q, exp_q;
  logic [CW-1:0] cnt_q;
  logic neg_q, done_q, dz_q;
  logic [VW-1:0] res_q;
  logic [VW-1:0] ml, mr;
  logic [VW:0]   trial;
  logic [VW-1:0] rem_sh;
  logic [VW-1:0] ones;

  assign ml = left_i[VW-1] ? (~left_i + 1'b1) : left_i;
  assign mr = right_i[VW-1] ? (~right_i + 1'b1) : right_i;
  assign rem_sh = {rem_q[VW-2:0], quo_q[VW-1]};
  assign trial = {rem_q, quo_q[VW-1]} - {1'b0, div_q};
  assign ones = '1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (start_i) begin
            op_q <= op_i;
            dz_q <= 1'b0;
            case (op_i)
              OpAdd: begin res_q <= left_i + right_i; done_q <= 1'b1; end
              OpSub: begin res_q <= left_i - right_i; done_q <= 1'b1; end
              OpMul: begin res_q <= left_i * right_i; done_q <= 1'b1; end
              OpDiv, OpMod: begin
                if (right_i == '0) begin
                  res_q <= '0; dz_q <= 1'b1; done_q <= 1'b1;
                end else begin
                  rem_q <= '0; quo_q <= ml; div_q <= mr;
                  neg_q <= (op_i == OpDiv) ? (left_i[VW-1] ^ right_i[VW-1])
                                           : left_i[VW-1];
                  cnt_q <= CW'(VW);
                  state_q <= SDiv;
                end
              end
              default: begin
                if (right_i[VW-1]) begin
                  done_q <= 1'b1;
                  if (left_i == '0) begin
                    res_q <= '0; dz_q <= 1'b1;
                  end else if (left_i == VW'(1)) begin
                    res_q <= VW'(1);
                  end else if (left_i == ones) begin
                    res_q <= right_i[0] ? ones : VW'(1);
                  end else begin
                    res_q <= '0;
                  end
                end else begin
                  acc_q <= VW'(1); base_q <= left_i; exp_q <= right_i;
                  cnt_q <= CW'(VW);
                  state_q <= SPowMul;
                end
              end
            endcase
          end
        end
        SDiv: begin
          if (!trial[VW]) begin
            rem_q <= trial[VW-1:0];
            quo_q <= {quo_q[VW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[VW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            state_q <= SIdle;
            done_q  <= 1'b1;
            if (op_q == OpDiv) begin
              res_q <= neg_q ? (~{quo_q[VW-2:0], ~trial[VW]} + 1'b1)
                             : {quo_q[VW-2:0], ~trial[VW]};
            end else begin
              res_q <= neg_q ? (~(trial[VW] ? rem_sh : trial[VW-1:0]) + 1'b1)
                             : (trial[VW] ? rem_sh : trial[VW-1:0]);
            end
          end
        end
        SPowMul: begin
          if (exp_q[0]) begin
            acc_q <= acc_q * base_q;
          end
          state_q <= SPowSq;
        end
        default: begin
          base_q <= base_q * base_q;
          exp_q  <= exp_q >> 1;
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            state_q <= SIdle;
            done_q  <= 1'b1;
            res_q   <= acc_q;
          end else begin
            state_q <= SPowMul;
          end
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;
  assign dz_o     = dz_q;
endmodule

FILE: hw/rtl/pee_datapath.sv
// Datapath: operand stack in RAM, count, flags, operand latches, unit and output register.
// Depends on pee_pkg, pee_ram and pee_alu.
module pee_datapath import pee_pkg::*; #(
  parameter int Depth = 32,
  parameter int VW    = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  logic [7:0]    char_code_i,
  input  logic          end_i,
  output sts_t          sts_o,
  output logic [VW-1:0] value_o,
  output logic          uf_o,
  output logic          of_o,
  output logic          dz_o
);
  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);
  logic [7:0] ch_q;
  logic last_q;
  logic [CW-1:0] cnt_q;
  logic uf_q, of_q, dz_q, rvalid_q;
  logic [VW-1:0] left_q, right_q, val_q;
  logic uo_q, oo_q, do_q;
  op_e op;
  logic we, alu_done, alu_dz;
  logic [AW-1:0] addr;
  logic [VW-1:0] wdata, rdata, alu_res;
  logic full, empty;

  assign full  = (cnt_q == CW'(Depth));
  assign empty = (cnt_q == '0);

  always_comb begin
    case (ch_q)
      CharPlus:  op = OpAdd;
      CharMinus: op = OpSub;
      CharStar:  op = OpMul;
      CharSlash: op = OpDiv;
      CharPct:   op = OpMod;
      default:   op = OpPow;
    endcase
  end

  assign sts_o.is_digit = (ch_q >= CharZero) && (ch_q <= CharNine);
  assign sts_o.is_op = (ch_q == CharPlus) || (ch_q == CharMinus) || (ch_q == CharStar) ||
                       (ch_q == CharSlash) || (ch_q == CharPct) || (ch_q == CharCaret);
  assign sts_o.last = last_q;
  assign sts_o.alu_done = alu_done;

  // Writes go to the count; reads go to count-1.
  assign we = (cmd_i.push_digit || cmd_i.push_res) && !full;
  assign addr = we ? cnt_q[AW-1:0] : (cnt_q[AW-1:0] - 1'b1);
  assign wdata = cmd_i.push_res ? alu_res : VW'(ch_q - CharZero);

  pee_ram #(.Width(VW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  pee_alu #(.VW(VW)) u_alu (
    .clk_i, .rst_ni, .start_i(cmd_i.start_alu), .op_i(op), .left_i(left_q),
    .right_i(right_q), .done_o(alu_done), .result_o(alu_res), .dz_o(alu_dz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; uf_q <= 1'b0; of_q <= 1'b0; dz_q <= 1'b0;
      rvalid_q <= 1'b0; last_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        ch_q <= char_code_i; last_q <= end_i;
      end
      if (cmd_i.rd_right || cmd_i.rd_left) begin
        rvalid_q <= !empty;
        if (empty) begin
          uf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      if (cmd_i.lat_right) right_q <= rvalid_q ? rdata : '0;
      if (cmd_i.lat_left) left_q <= rvalid_q ? rdata : '0;
      if (cmd_i.push_digit || cmd_i.push_res) begin
        if (full) begin
          of_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.push_res && alu_dz) dz_q <= 1'b1;
      if (cmd_i.rd_top) rvalid_q <= !empty;
      if (cmd_i.emit) begin
        val_q <= rvalid_q ? rdata : '0;
        uo_q <= uf_q; oo_q <= of_q; do_q <= dz_q;
        cnt_q <= '0; uf_q <= 1'b0; of_q <= 1'b0; dz_q <= 1'b0;
      end
    end
  end

  assign value_o = val_q;
  assign uf_o = uo_q;
  assign of_o = oo_q;
  assign dz_o = do_q;
endmodule

FILE: hw/rtl/pee_ctrl.sv
// Controller state machine for the postfix evaluator.
// Depends on pee_pkg.
module pee_ctrl import pee_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [3:0] {
    SIdle, SDecode, SRdRight, SRdLeft, SLatLeft, SStart, SWait, SRdTop, SEmit
  } state_e;
  state_e state_q;
  logic ovalid_q;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = ovalid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      SIdle:    cmd_o.load_in = in_valid_i;
      SDecode: begin
        cmd_o.push_digit = sts_i.is_digit;
        cmd_o.rd_right = sts_i.is_op;
        cmd_o.rd_top = !sts_i.is_op && sts_i.last && !sts_i.is_digit;
      end
      SRdRight: begin cmd_o.lat_right = 1'b1; cmd_o.rd_left = 1'b1; end
      SRdLeft:  cmd_o.lat_left = 1'b1;
      SLatLeft: cmd_o.start_alu = 1'b1;
      SStart:   ;
      SWait:    cmd_o.push_res = sts_i.alu_done;
      SRdTop:   cmd_o.rd_top = 1'b1;
      SEmit:    cmd_o.emit = !ovalid_q || out_ready_i;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        SIdle: if (in_valid_i) state_q <= SDecode;
        SDecode: begin
          if (sts_i.is_op) state_q <= SRdRight;
          else if (sts_i.last && sts_i.is_digit) state_q <= SRdTop;
          else if (sts_i.last) state_q <= SEmit;
          else state_q <= SIdle;
        end
        SRdRight: state_q <= SRdLeft;
        SRdLeft:  state_q <= SLatLeft;
        SLatLeft: state_q <= SWait;
        SStart:   state_q <= SWait;
        SWait: begin
          if (sts_i.alu_done) state_q <= sts_i.last ? SRdTop : SIdle;
        end
        SRdTop: state_q <= SEmit;
        SEmit: begin
          if (!ovalid_q || out_ready_i) begin
            ovalid_q <= 1'b1;
            state_q  <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

FILE: hw/rtl/postfix_expression_evaluator.sv
// Top level of the postfix (RPN) expression evaluator.
// Depends on pee_pkg, pee_ctrl, pee_datapath and the assertion macro header.
//
//   channel | direction | handshake               | payload
//   input   | in        | in_valid_i / in_ready_o | char_code_i, end_of_expression_i
//   output  | out       | out_valid_o/out_ready_i | value_o and three flags
//
// Per request: a digit or ignored character passes Idle and Decode; an operator then pops
// both operands and waits for the unit, which ends + - * and negative powers at start
// and steps / % ^ bit by bit. An end mark adds RdTop, Emit; only Emit on an ignored char.
// Reset clears the stack count, the flags and the controller; stack contents are unset.
// A result waits in the output register while a new expression starts; only the next
// result stalls until the previous one is taken.
`include "postfix_expression_evaluator_assert.svh"
module postfix_expression_evaluator import pee_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    char_code_i,
  input  logic                          end_of_expression_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic                          underflow_seen_o,
  output logic                          overflow_seen_o,
  output logic                          divide_by_zero_seen_o
);
  cmd_t cmd;
  sts_t sts;

  // The controller sequences each request; the datapath holds the stack and the unit.
  pee_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pee_datapath #(.Depth(STACK_DEPTH), .VW(VALUE_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .char_code_i, .end_i(end_of_expression_i),
    .sts_o(sts), .value_o(value_o), .uf_o(underflow_seen_o),
    .of_o(overflow_seen_o), .dz_o(divide_by_zero_seen_o)
  );

  // A result is only loaded when the output register is free or being drained.
  `PEE_ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd.emit, !out_valid_o || out_ready_i)
  // Loading the output register always presents a result next cycle.
  `PEE_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, cmd.emit, out_valid_o)
  // No new request is taken when the unit is started.
  `PEE_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, cmd.start_alu, !in_ready_o)
endmodule
